// ===== design/cfpa_pkg.sv =====
// ----------------------------------------------------------------------------
// cfpa_pkg
// Types, opcodes and the square root step used by the complex alu unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cfpa_pkg;

    typedef logic [2:0] opcode_t;

    localparam opcode_t OP_ADD  = 3'd0;
    localparam opcode_t OP_SUB  = 3'd1;
    localparam opcode_t OP_MUL  = 3'd2;
    localparam opcode_t OP_CONJ = 3'd3;
    localparam opcode_t OP_MAG  = 3'd4;

    // root bits resolved per pipeline stage
    localparam int SQ_STEPS  = 4;
    localparam int SQ_BITS   = 32;
    localparam int SQ_STAGES = SQ_BITS / SQ_STEPS;

    typedef struct packed {
        opcode_t            op;
        logic signed [31:0] ar;
        logic signed [31:0] ai;
        logic signed [31:0] br;
        logic signed [31:0] bi;
    } in_t;

    typedef struct packed {
        opcode_t            op;
        logic signed [63:0] p_rr;
        logic signed [63:0] p_ii;
        logic signed [63:0] p_ri;
        logic signed [63:0] p_ir;
        logic [31:0]        res_re;
        logic [31:0]        res_im;
        logic               ovf;
    } prod_t;

    typedef struct packed {
        opcode_t     op;
        logic [31:0] res_re;
        logic [31:0] res_im;
        logic        ovf;
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } sq_t;

    // one restoring digit step: takes the next two radicand bits
    function automatic sq_t sqrt_step(input sq_t s);
        sq_t         o;
        logic [33:0] rem_sh;
        logic [33:0] trial;
        logic        ge;
        o      = s;
        rem_sh = {s.rem[31:0], s.rad[63:62]};
        trial  = {s.root, 2'b01};
        ge     = (rem_sh >= trial);
        o.rem  = ge ? (rem_sh - trial) : rem_sh;
        o.root = {s.root[30:0], ge};
        o.rad  = {s.rad[61:0], 2'b00};
        return o;
    endfunction

endpackage

`default_nettype wire

// ===== design/complex_fixed_point_alu_unit.sv =====
// ----------------------------------------------------------------------------
// complex_fixed_point_alu_unit
// Pipelined complex alu: add, subtract, multiply, conjugate and magnitude.
// ----------------------------------------------------------------------------
// Input channel s_*: one request per beat, s_tuser carries the opcode and
// s_tdata the operands A and B. Output channel m_*: the complex result in
// m_tdata and the saturation flag in m_tuser.
// Every opcode runs through the same pipeline, so results leave in request
// order. The pipeline is an input stage, a multiplier stage, a combine and
// saturate stage, and 8 square root stages that resolve 4 root bits each.
// Throughput is one request per cycle while the receiver keeps m_tready high.
// The four 32x32 multipliers are shared: for magnitude two of them form the squares.
// Each stage has its own valid bit and takes new data when it is empty or
// its successor moves, so bubbles close up while the receiver stalls and
// s_tready drops only once every stage holds a request.
// Reset (aresetn low at a clock edge) empties the pipeline; m_tvalid is low
// afterwards. The block keeps no other state.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_fixed_point_alu_unit
    import cfpa_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // a_re, a_im, b_re, b_im
    input  wire logic [2:0]   s_tuser,   // opcode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,   // res_re, res_im
    output logic [0:0]        m_tuser    // overflow
);

    localparam int NST = SQ_STAGES + 3;
    localparam int SH  = 32 - DATA_WIDTH;
    localparam logic signed [65:0] SMAX = (66'sd1 <<< (DATA_WIDTH - 1)) - 66'sd1;
    localparam logic signed [65:0] SMIN = -SMAX - 66'sd1;

    function automatic logic signed [31:0] sx(input logic [31:0] x);
        return $signed(x << SH) >>> SH;
    endfunction

    function automatic logic [31:0] clamp(input logic signed [65:0] v);
        if (v > SMAX) begin
            return SMAX[31:0];
        end else if (v < SMIN) begin
            return SMIN[31:0];
        end
        return v[31:0];
    endfunction

    function automatic logic clipped(input logic signed [65:0] v);
        return (v > SMAX) || (v < SMIN);
    endfunction

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] rdy;
    in_t            st0_reg;
    prod_t          st1_reg;
    prod_t          st1_next;
    sq_t            sq0_next;
    sq_t            sq_reg  [SQ_STAGES+1];
    sq_t            sq_next [SQ_STAGES+1];

    // ready ripples back from the output; an empty stage always takes data
    always_comb begin
        rdy[NST-1] = m_tready || !valid_reg[NST-1];
        for (int k = NST - 2; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = valid_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (rdy[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (rdy[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // multiplier and simple operations
    always_comb begin
        logic signed [31:0] mb_re;
        logic signed [31:0] mb_im;
        logic signed [65:0] v_re;
        logic signed [65:0] v_im;
        mb_re = (st0_reg.op == OP_MAG) ? st0_reg.ar : st0_reg.br;
        mb_im = (st0_reg.op == OP_MAG) ? st0_reg.ai : st0_reg.bi;
        st1_next.op   = st0_reg.op;
        st1_next.p_rr = st0_reg.ar * mb_re;
        st1_next.p_ii = st0_reg.ai * mb_im;
        st1_next.p_ri = st0_reg.ar * mb_im;
        st1_next.p_ir = st0_reg.ai * mb_re;
        v_re = '0;
        v_im = '0;
        case (st0_reg.op)
            OP_ADD: begin
                v_re = 66'(st0_reg.ar) + 66'(st0_reg.br);
                v_im = 66'(st0_reg.ai) + 66'(st0_reg.bi);
            end
            OP_SUB: begin
                v_re = 66'(st0_reg.ar) - 66'(st0_reg.br);
                v_im = 66'(st0_reg.ai) - 66'(st0_reg.bi);
            end
            OP_CONJ: begin
                v_re = 66'(st0_reg.ar);
                v_im = -66'(st0_reg.ai);
            end
            default: begin
                v_re = '0;
                v_im = '0;
            end
        endcase
        st1_next.res_re = clamp(v_re);
        st1_next.res_im = clamp(v_im);
        st1_next.ovf    = clipped(v_re) || clipped(v_im);
    end

    // combine products, saturate the multiply, set up the radicand
    always_comb begin
        logic signed [65:0] m_re;
        logic signed [65:0] m_im;
        m_re = (66'(st1_reg.p_rr) - 66'(st1_reg.p_ii)) >>> FRAC_BITS;
        m_im = (66'(st1_reg.p_ri) + 66'(st1_reg.p_ir)) >>> FRAC_BITS;
        sq0_next.op     = st1_reg.op;
        sq0_next.res_re = st1_reg.res_re;
        sq0_next.res_im = st1_reg.res_im;
        sq0_next.ovf    = st1_reg.ovf;
        sq0_next.rad    = '0;
        sq0_next.rem    = '0;
        sq0_next.root   = '0;
        if (st1_reg.op == OP_MUL) begin
            sq0_next.res_re = clamp(m_re);
            sq0_next.res_im = clamp(m_im);
            sq0_next.ovf    = clipped(m_re) || clipped(m_im);
        end else if (st1_reg.op == OP_MAG) begin
            sq0_next.rad = 64'(st1_reg.p_rr) + 64'(st1_reg.p_ii);
        end
    end

    // square root stages, the last one also saturates the magnitude
    always_comb begin
        sq_t s;
        sq_next[0] = sq0_next;
        for (int k = 1; k <= SQ_STAGES; k++) begin
            s = sq_reg[k-1];
            for (int j = 0; j < SQ_STEPS; j++) begin
                s = sqrt_step(s);
            end
            if (k == SQ_STAGES && s.op == OP_MAG) begin
                s.res_im = '0;
                if (66'(s.root) > SMAX) begin
                    s.res_re = SMAX[31:0];
                    s.ovf    = 1'b1;
                end else begin
                    s.res_re = s.root;
                    s.ovf    = 1'b0;
                end
            end
            sq_next[k] = s;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            st0_reg.op <= s_tuser;
            st0_reg.ar <= sx(s_tdata[31:0]);
            st0_reg.ai <= sx(s_tdata[63:32]);
            st0_reg.br <= sx(s_tdata[95:64]);
            st0_reg.bi <= sx(s_tdata[127:96]);
        end
        if (rdy[1]) begin
            st1_reg <= st1_next;
        end
        for (int k = 0; k <= SQ_STAGES; k++) begin
            if (rdy[k+2]) begin
                sq_reg[k] <= sq_next[k];
            end
        end
    end

    assign m_tdata = {sq_reg[SQ_STAGES].res_im, sq_reg[SQ_STAGES].res_re};
    assign m_tuser = sq_reg[SQ_STAGES].ovf;

endmodule

`default_nettype wire

// ===== design/cfpa_checker.sv =====
// ----------------------------------------------------------------------------
// cfpa_checker
// Port level checks for the complex alu, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cfpa_checker #(
    parameter int DATA_WIDTH = 32
) (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [127:0] s_tdata,
    input wire logic [2:0]   s_tuser,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [63:0]  m_tdata,
    input wire logic [0:0]   m_tuser
);

    localparam logic signed [32:0] SMAX = (33'sd1 <<< (DATA_WIDTH - 1)) - 33'sd1;
    localparam logic [31:0] PMAX = SMAX[31:0];
    localparam logic [31:0] NMIN = ~SMAX[31:0];

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_ovf_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
        (m_tdata[31:0] == PMAX || m_tdata[31:0] == NMIN ||
         m_tdata[63:32] == PMAX || m_tdata[63:32] == NMIN))
        else $error("overflow without a saturated part");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind complex_fixed_point_alu_unit cfpa_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cfpa_checker (.*);

`default_nettype wire
